[rtl/same_conv2d_stream_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the same_conv2d_stream block
// Short forms for the concurrent checks used by the block's checker.
// ---------------------------------------------------------------------------
`ifndef SAME_CONV2D_STREAM_MACROS_SVH
`define SAME_CONV2D_STREAM_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define SC2D_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same_conv2d_stream: check failed");

// Next-cycle implication, switched off while reset is held.
`define SC2D_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("same_conv2d_stream: check failed");

// Next-cycle implication that also holds across reset.
`define SC2D_ASSERT_NXT_NR(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("same_conv2d_stream: check failed");

`endif

[rtl/sc2d_pkg.sv]
// ---------------------------------------------------------------------------
// sc2d_pkg
// Types and constants shared by the streaming 2D convolution block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sc2d_pkg;

    // Fixed field widths.
    localparam int COEF_DIM   = 4;
    localparam int CI_W       = $clog2(COEF_DIM);
    localparam int PIX_W      = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 32;
    localparam int ROW_W      = 34;
    localparam int SUM_W      = 40;
    localparam int DIM_W      = 11;
    localparam int KDIM_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_ROWS     = 3'd0,
        REG_IMAGE_COLS     = 3'd1,
        REG_KERNEL_ROWS    = 3'd2,
        REG_KERNEL_COLS    = 3'd3,
        REG_COEF_ROW_ZERO  = 3'd4,
        REG_COEF_ROW_ONE   = 3'd5,
        REG_COEF_ROW_TWO   = 3'd6,
        REG_COEF_ROW_THREE = 3'd7
    } t_cfg_idx;

    // Input request: one image sample.
    typedef struct packed {
        logic signed [PIX_W-1:0] pixel;
        logic                    flush;
    } t_in_req;

    // Output request: one convolution result.
    typedef struct packed {
        logic signed [SUM_W-1:0] conv_sum;
        logic                    frame_end;
    } t_out_req;

    // One kernel row, column 0 in the low bits.
    typedef logic [COEF_DIM-1:0][COEF_W-1:0] t_coef_row;

    // Per-item decisions taken at acceptance.
    typedef struct packed {
        logic                res;
        logic                last;
        logic [COEF_DIM-1:0] row_ok;
        logic [COEF_DIM-1:0] col_ok;
    } t_pos;

    // Controls handed to one cell for its product lanes.
    typedef struct packed {
        logic                row_ok;
        logic [COEF_DIM-1:0] col_ok;
        logic [KDIM_W-1:0]   kc;
    } t_cell_ctl;

endpackage

[rtl/sc2d_cell.sv]
// ---------------------------------------------------------------------------
// sc2d_cell
// One window row: a line delay (not in the last cell), four window taps,
// four multipliers, a registered row sum; its line output feeds the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sc2d_cell
    import sc2d_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter bit HAS_LINE = 1'b1,
    localparam int AW      = $clog2(MAX_COLS)
) (
    input  logic                    i_clk,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_rd_addr,
    input  logic                    i_sh_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic signed [PIX_W-1:0] i_din,
    output logic signed [PIX_W-1:0] o_dout,
    input  logic                    i_mul_en,
    input  t_cell_ctl               i_ctl,
    input  t_coef_row               i_coef,
    input  logic                    i_sum_en,
    output logic signed [ROW_W-1:0] o_row_sum
);

    logic signed [PIX_W-1:0]  r_win [COEF_DIM];
    logic signed [PIX_W-1:0]  w_tap [COEF_DIM];
    logic signed [COEF_W-1:0] w_cf  [COEF_DIM];
    logic [KDIM_W-1:0]        w_ci  [COEF_DIM];
    logic signed [PROD_W-1:0] r_prod [COEF_DIM];
    logic signed [ROW_W-1:0]  w_row;
    logic signed [ROW_W-1:0]  r_row;

    // Window taps: tap e holds the sample e items older than tap 0.
    always_ff @(posedge i_clk) begin
        if (i_sh_en) begin
            r_win[0] <= i_din;
            for (int e = 1; e < COEF_DIM; e++) begin
                r_win[e] <= r_win[e-1];
            end
        end
    end

    // Line delay of one image row, with a bypass when read and write collide.
    generate
        if (HAS_LINE) begin : g_line
            logic signed [PIX_W-1:0] r_mem [MAX_COLS];
            logic signed [PIX_W-1:0] r_rd;

            always_ff @(posedge i_clk) begin
                if (i_sh_en) begin
                    r_mem[i_wr_addr] <= i_din;
                end
                if (i_rd_en) begin
                    if (i_sh_en && (i_wr_addr == i_rd_addr)) begin
                        r_rd <= i_din;
                    end else begin
                        r_rd <= r_mem[i_rd_addr];
                    end
                end
            end

            assign o_dout = r_rd;
        end else begin : g_no_line
            // The last cell feeds nothing further down the chain.
            assign o_dout = '0;
        end
    endgenerate

    // Lane selection: tap e pairs with kernel column kc-1-e.
    always_comb begin
        for (int e = 0; e < COEF_DIM; e++) begin
            w_ci[e]  = i_ctl.kc - KDIM_W'(e) - KDIM_W'(1);
            w_cf[e]  = $signed(i_coef[w_ci[e][CI_W-1:0]]);
            w_tap[e] = (i_ctl.row_ok && i_ctl.col_ok[e]) ? r_win[e] : '0;
        end
    end

    // Product registers.
    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            for (int e = 0; e < COEF_DIM; e++) begin
                r_prod[e] <= w_cf[e] * w_tap[e];
            end
        end
    end

    // Row sum of the four products.
    always_comb begin
        w_row = '0;
        for (int e = 0; e < COEF_DIM; e++) begin
            w_row = w_row + ROW_W'(r_prod[e]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sum_en) begin
            r_row <= w_row;
        end
    end

    assign o_row_sum = r_row;

endmodule

[rtl/sc2d_pos.sv]
// ---------------------------------------------------------------------------
// sc2d_pos
// Raster position tracking: column pointer for the line delays, output
// position, and the per-item result, frame end and border masks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sc2d_pos
    import sc2d_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    localparam int AW      = $clog2(MAX_COLS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic              i_clear,
    input  logic [DIM_W-1:0]  i_rows,
    input  logic [DIM_W-1:0]  i_cols,
    input  logic [KDIM_W-1:0] i_kr,
    input  logic [KDIM_W-1:0] i_kc,
    input  logic [KDIM_W-1:0] i_pb,
    input  logic [KDIM_W-1:0] i_pr,
    output logic [AW-1:0]     o_col,
    output t_pos              o_pos
);

    localparam int XW = DIM_W + 2;

    logic [AW-1:0]    r_col;
    logic [1:0]       r_row_sat;
    logic [DIM_W-1:0] r_oi;
    logic [AW-1:0]    r_oj;

    logic [XW-1:0] x_rows, x_cols, x_col, x_row, x_oi, x_oj, x_pb, x_pr;
    logic          w_start;
    logic          w_last;

    always_comb begin
        x_rows = XW'(i_rows);
        x_cols = XW'(i_cols);
        x_col  = XW'(r_col);
        x_row  = XW'(r_row_sat);
        x_oi   = XW'(r_oi);
        x_oj   = XW'(r_oj);
        x_pb   = XW'(i_pb);
        x_pr   = XW'(i_pr);
    end

    // Results start once the item count reaches the latency pb*cols + pr.
    always_comb begin
        if (x_cols == XW'(1)) begin
            w_start = (x_row >= (x_pb + x_pr));
        end else begin
            w_start = (x_row > x_pb) || ((x_row == x_pb) && (x_col >= x_pr));
        end
        w_last = w_start && (x_oi == x_rows - XW'(1)) && (x_oj == x_cols - XW'(1));
    end

    // Border masks for the output pixel: cell d sees image row oi+pb-d,
    // tap e sees image column oj+pr-e.
    always_comb begin
        o_pos.res  = w_start;
        o_pos.last = w_last;
        for (int d = 0; d < COEF_DIM; d++) begin
            o_pos.row_ok[d] = (KDIM_W'(d) < i_kr) && ((x_oi + x_pb) >= XW'(d))
                              && ((x_oi + x_pb) < (x_rows + XW'(d)));
            o_pos.col_ok[d] = (KDIM_W'(d) < i_kc) && ((x_oj + x_pr) >= XW'(d))
                              && ((x_oj + x_pr) < (x_cols + XW'(d)));
        end
    end

    assign o_col = r_col;

    // Counters advance per accepted request and restart after the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col     <= '0;
            r_row_sat <= '0;
            r_oi      <= '0;
            r_oj      <= '0;
        end else if (i_acc) begin
            if (w_last) begin
                r_col     <= '0;
                r_row_sat <= '0;
                r_oi      <= '0;
                r_oj      <= '0;
            end else begin
                if (x_col == x_cols - XW'(1)) begin
                    r_col <= '0;
                    if (r_row_sat != 2'd3) begin
                        r_row_sat <= r_row_sat + 2'd1;
                    end
                end else begin
                    r_col <= r_col + AW'(1);
                end
                if (w_start) begin
                    if (x_oj == x_cols - XW'(1)) begin
                        r_oj <= '0;
                        r_oi <= r_oi + DIM_W'(1);
                    end else begin
                        r_oj <= r_oj + AW'(1);
                    end
                end
            end
        end
    end

endmodule

[rtl/same_conv2d_stream.sv]
// ---------------------------------------------------------------------------
// same_conv2d_stream
// Streaming 'same'-size 2D correlation with zero padding, kernel up to 4x4.
// ---------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the input channel (valid/ready); a flush
//   request stands for a zero sample. Output pixel n leaves on the output
//   channel once request n+L has been taken, where L is the bottom padding
//   times cols plus the right padding; after a frame, L flush requests drain
//   the remaining outputs and the next frame begins. frame_end marks the
//   last output of a frame.
//   Configuration is written through a plain write port while idle; any
//   geometry write restarts the frame, coefficient writes do not.
//   Throughput: one request per clock while the output is not stalled. A
//   request that yields a result passes the input register, the window taps,
//   one product stage, a row sum stage and the output register on its way.
//   Reset: all pipeline stages empty, frame position cleared, dimensions 1,
//   coefficients zero.
//   When the receiver stalls, results stay in the output register and the
//   stages behind it keep filling; input ready drops only once they are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module same_conv2d_stream
    import sc2d_pkg::*;
#(
    parameter int KERNEL_MAX = 4,
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_req               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_req              o_out_data,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int NC = (KERNEL_MAX < COEF_DIM) ? KERNEL_MAX : COEF_DIM;
    localparam int AW = $clog2(MAX_COLS);

    // Configuration registers.
    logic [DIM_W-1:0]  r_image_rows, r_image_cols;
    logic [KDIM_W-1:0] r_kernel_rows, r_kernel_cols;
    t_coef_row         r_coef [COEF_DIM];
    logic              w_geo_wr;

    // Effective geometry.
    logic [DIM_W-1:0]  w_rows, w_cols;
    logic [KDIM_W-1:0] w_kr, w_kc, w_pb, w_pr;

    // Pipeline control.
    logic w_acc, w_can1, w_can2, w_can3, w_can4, w_can_out;
    logic w_m1, w_m2, w_m2x, w_m3, w_m4;

    logic                    r_s1_v;
    logic signed [PIX_W-1:0] r_s1_pix;
    logic [AW-1:0]           r_s1_col;
    t_pos                    r_s1_pos;
    logic                    r_s2_v;
    t_pos                    r_s2_pos;
    logic                    r_s3_v, r_s3_last;
    logic                    r_s4_v, r_s4_last;
    logic                    r_out_v;
    t_out_req                r_out;

    logic [AW-1:0] w_col;
    t_pos          w_pos;

    logic signed [PIX_W-1:0] w_din  [NC];
    logic signed [PIX_W-1:0] w_dout [NC];
    logic signed [ROW_W-1:0] w_row  [NC];
    t_cell_ctl               w_ctl  [NC];
    t_coef_row               w_coef [NC];
    logic [KDIM_W-1:0]       w_ki   [NC];
    logic signed [SUM_W-1:0] w_total;

    // Register decoder: geometry writes restart the frame.
    always_comb begin
        unique case (t_cfg_idx'(i_cfg_index)) inside
            REG_IMAGE_ROWS, REG_IMAGE_COLS, REG_KERNEL_ROWS, REG_KERNEL_COLS:
                w_geo_wr = i_cfg_wr_en;
            default: w_geo_wr = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_rows  <= DIM_W'(1);
            r_image_cols  <= DIM_W'(1);
            r_kernel_rows <= KDIM_W'(1);
            r_kernel_cols <= KDIM_W'(1);
            for (int k = 0; k < COEF_DIM; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_IMAGE_ROWS:     r_image_rows  <= i_cfg_wdata[DIM_W-1:0];
                REG_IMAGE_COLS:     r_image_cols  <= i_cfg_wdata[DIM_W-1:0];
                REG_KERNEL_ROWS:    r_kernel_rows <= i_cfg_wdata[KDIM_W-1:0];
                REG_KERNEL_COLS:    r_kernel_cols <= i_cfg_wdata[KDIM_W-1:0];
                REG_COEF_ROW_ZERO:  r_coef[0]     <= i_cfg_wdata;
                REG_COEF_ROW_ONE:   r_coef[1]     <= i_cfg_wdata;
                REG_COEF_ROW_TWO:   r_coef[2]     <= i_cfg_wdata;
                REG_COEF_ROW_THREE: r_coef[3]     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the geometry to its legal range and derive the padding.
    always_comb begin
        if (r_image_rows == '0) begin
            w_rows = DIM_W'(1);
        end else if (32'(r_image_rows) > MAX_ROWS) begin
            w_rows = DIM_W'(MAX_ROWS);
        end else begin
            w_rows = r_image_rows;
        end
        if (r_image_cols == '0) begin
            w_cols = DIM_W'(1);
        end else if (32'(r_image_cols) > MAX_COLS) begin
            w_cols = DIM_W'(MAX_COLS);
        end else begin
            w_cols = r_image_cols;
        end
        if (r_kernel_rows == '0) begin
            w_kr = KDIM_W'(1);
        end else if (32'(r_kernel_rows) > NC) begin
            w_kr = KDIM_W'(NC);
        end else begin
            w_kr = r_kernel_rows;
        end
        if (r_kernel_cols == '0) begin
            w_kc = KDIM_W'(1);
        end else if (32'(r_kernel_cols) > NC) begin
            w_kc = KDIM_W'(NC);
        end else begin
            w_kc = r_kernel_cols;
        end
        w_pb = w_kr - KDIM_W'(1) - (w_kr >> 1);
        w_pr = w_kc - KDIM_W'(1) - (w_kc >> 1);
    end

    // Stages move when the next has room; stage 2 drops items without a result.
    always_comb begin
        w_can_out = !r_out_v || i_out_ready;
        w_m4      = r_s4_v && w_can_out;
        w_can4    = !r_s4_v || w_can_out;
        w_m3      = r_s3_v && w_can4;
        w_can3    = !r_s3_v || w_can4;
        w_m2      = r_s2_v && r_s2_pos.res && w_can3;
        w_m2x     = r_s2_v && (!r_s2_pos.res || w_can3);
        w_can2    = !r_s2_v || w_m2x;
        w_m1      = r_s1_v && w_can2;
        w_can1    = !r_s1_v || w_can2;
        w_acc     = i_in_valid && w_can1;
    end

    assign o_in_ready = w_can1;

    // Frame position and per-request decisions.
    sc2d_pos #(
        .MAX_COLS (MAX_COLS)
    ) u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_clear (w_geo_wr),
        .i_rows  (w_rows),
        .i_cols  (w_cols),
        .i_kr    (w_kr),
        .i_kc    (w_kc),
        .i_pb    (w_pb),
        .i_pr    (w_pr),
        .o_col   (w_col),
        .o_pos   (w_pos)
    );

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_s1_v  <= w_acc || (r_s1_v && !w_m1);
            r_s2_v  <= w_m1 || (r_s2_v && !w_m2x);
            r_s3_v  <= w_m2 || (r_s3_v && !w_m3);
            r_s4_v  <= w_m3 || (r_s4_v && !w_m4);
            r_out_v <= w_m4 || (r_out_v && !i_out_ready);
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_pix <= i_in_data.flush ? '0 : i_in_data.pixel;
            r_s1_col <= w_col;
            r_s1_pos <= w_pos;
        end
        if (w_m1) begin
            r_s2_pos <= r_s1_pos;
        end
        if (w_m2) begin
            r_s3_last <= r_s2_pos.last;
        end
        if (w_m3) begin
            r_s4_last <= r_s3_last;
        end
        if (w_m4) begin
            r_out.conv_sum  <= w_total;
            r_out.frame_end <= r_s4_last;
        end
    end

    // Cell d covers kernel row kr-1-d; cell d>0 is fed by the line delay of d-1.
    always_comb begin
        for (int d = 0; d < NC; d++) begin
            w_din[d]  = (d == 0) ? r_s1_pix : w_dout[(d == 0) ? 0 : d - 1];
            w_ki[d]   = w_kr - KDIM_W'(1) - KDIM_W'(d);
            w_coef[d] = r_coef[w_ki[d][CI_W-1:0]];
            w_ctl[d].row_ok = r_s2_pos.row_ok[d];
            w_ctl[d].col_ok = r_s2_pos.col_ok;
            w_ctl[d].kc     = w_kc;
        end
    end

    generate
        for (genvar d = 0; d < NC; d++) begin : g_cell
            sc2d_cell #(
                .MAX_COLS (MAX_COLS),
                .HAS_LINE (d < NC - 1)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rd_en   (w_acc),
                .i_rd_addr (w_col),
                .i_sh_en   (w_m1),
                .i_wr_addr (r_s1_col),
                .i_din     (w_din[d]),
                .o_dout    (w_dout[d]),
                .i_mul_en  (w_m2),
                .i_ctl     (w_ctl[d]),
                .i_coef    (w_coef[d]),
                .i_sum_en  (w_m3),
                .o_row_sum (w_row[d])
            );
        end
    endgenerate

    // Final sum over the row sums.
    always_comb begin
        w_total = '0;
        for (int d = 0; d < NC; d++) begin
            w_total = w_total + SUM_W'(w_row[d]);
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

[rtl/sc2d_check.sv]
// ---------------------------------------------------------------------------
// sc2d_check
// Port-level checks for same_conv2d_stream, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "same_conv2d_stream_macros.svh"

module sc2d_check
    import sc2d_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_req o_out_data
);

    // A stalled result stays offered.
    `SC2D_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // A stalled result keeps its value.
    `SC2D_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_data))

    // With the output register empty, the whole chain has room for a request.
    `SC2D_ASSERT_IMP(a_ready_when_drained, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // Reset empties the output register.
    `SC2D_ASSERT_NXT_NR(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind same_conv2d_stream sc2d_check u_sc2d_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
